[rtl/tpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared sizes, types and codes of the trie prefix counter.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int NODE_POOL  = 4096;
  localparam int ALPHABET   = 26;
  localparam int COUNT_BITS = 16;

  localparam int NODE_W     = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int NEXT_W     = $clog2(NODE_POOL + 1);
  localparam int SLOT_DEPTH = NODE_POOL * ALPHABET;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);

  localparam int LETTER_W    = 5;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_COUNT_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [NEXT_W-1:0]     next_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // One word of the node memory: the slot that owns the node, and its count.
  typedef struct packed {
    slot_t  back;
    count_t count;
  } node_word_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    node_t wdata;
    logic  re;
    slot_t raddr;
  } child_req_t;

  typedef struct packed {
    logic       we;
    node_t      waddr;
    node_word_t wdata;
    logic       re;
    node_t      raddr;
  } node_req_t;

  typedef struct packed {
    logic             status;
    logic [OUT_COUNT_W-1:0] prefix_count;
  } result_t;

  function automatic logic [OUT_COUNT_W-1:0] count_to_field(count_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[OUT_COUNT_W-1:0];
  endfunction

endpackage

[rtl/tpc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tpc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_ctrl
// Walk sequencer: reads the child slot, then the node word, then updates.
// ----------------------------------------------------------------------------
module tpc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tpc_pkg::KIND_W-1:0]   in_kind,
  input  logic [tpc_pkg::LETTER_W-1:0] in_letter,
  input  logic                         in_last,
  output tpc_pkg::child_req_t          child_req,
  input  tpc_pkg::node_t               child_rdata,
  output tpc_pkg::node_req_t           node_req,
  input  tpc_pkg::node_word_t          node_rdata,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tpc_pkg::result_t             res
);

  typedef enum logic [1:0] {S_IDLE, S_CHILD, S_NODE, S_FIN} state_t;

  state_t                       state_r, state_nxt;
  tpc_pkg::node_t               cur_r, cur_nxt;
  tpc_pkg::next_t               next_free_r, next_free_nxt;
  logic                         broken_r, broken_nxt;
  logic                         full_r, full_nxt;
  logic                         clr_r, clr_nxt;
  tpc_pkg::slot_t               clr_idx_r, clr_idx_nxt;
  tpc_pkg::slot_t               slot_r, slot_nxt;
  logic [tpc_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                         last_r, last_nxt;
  tpc_pkg::result_t             res_r, res_nxt;

  logic           accept;
  logic           letter_ok;
  logic           active;
  logic           hit;
  tpc_pkg::slot_t slot_calc;
  tpc_pkg::count_t cnt_inc;
  tpc_pkg::count_t val;

  assign in_ready  = (state_r == S_IDLE) && !clr_r;
  assign accept    = in_valid && in_ready;
  assign letter_ok = {27'd0, in_letter} < 32'(tpc_pkg::ALPHABET);
  assign active    = !broken_r && !full_r;
  assign slot_calc = tpc_pkg::SLOT_W'(cur_r) * tpc_pkg::SLOT_W'(tpc_pkg::ALPHABET)
                   + tpc_pkg::SLOT_W'(in_letter);

  // A stored child counts only if it was handed out since the last clear and
  // the node still names this slot as its owner.
  assign hit = (child_rdata != '0)
            && (tpc_pkg::NEXT_W'(child_rdata) < next_free_r)
            && (node_rdata.back == slot_r);

  assign cnt_inc = (node_rdata.count == tpc_pkg::COUNT_MAX) ? node_rdata.count
                 : node_rdata.count + tpc_pkg::COUNT_BITS'(1);

  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    next_free_nxt = next_free_r;
    broken_nxt    = broken_r;
    full_nxt      = full_r;
    clr_nxt       = clr_r;
    clr_idx_nxt   = clr_idx_r;
    slot_nxt      = slot_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    child_req     = '0;
    node_req      = '0;
    val           = '0;

    if (clr_r) begin
      child_req.we    = 1'b1;
      child_req.waddr = clr_idx_r;
      child_req.wdata = '0;
      clr_idx_nxt     = clr_idx_r + tpc_pkg::SLOT_W'(1);
      if (clr_idx_r == tpc_pkg::SLOT_W'(tpc_pkg::SLOT_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          last_nxt = in_last;
          slot_nxt = slot_calc;
          if (in_kind == tpc_pkg::KIND_CLEAR) begin
            next_free_nxt = tpc_pkg::NEXT_W'(1);
            cur_nxt       = '0;
            broken_nxt    = 1'b0;
            full_nxt      = 1'b0;
          end else if (in_kind == tpc_pkg::KIND_INSERT || in_kind == tpc_pkg::KIND_QUERY) begin
            if (active && letter_ok) begin
              child_req.re    = 1'b1;
              child_req.raddr = slot_calc;
              state_nxt       = S_CHILD;
            end else begin
              if (active) begin
                broken_nxt = 1'b1;
              end
              res_nxt.prefix_count = '0;
              res_nxt.status       = full_r;
              if (in_last) begin
                state_nxt = S_FIN;
              end
            end
          end
        end
      end
      S_CHILD: begin
        node_req.re    = 1'b1;
        node_req.raddr = child_rdata;
        state_nxt      = S_NODE;
      end
      S_NODE: begin
        if (kind_r == tpc_pkg::KIND_INSERT) begin
          if (hit) begin
            node_req.we          = 1'b1;
            node_req.waddr       = child_rdata;
            node_req.wdata.back  = node_rdata.back;
            node_req.wdata.count = cnt_inc;
            cur_nxt              = child_rdata;
            val                  = cnt_inc;
          end else if (next_free_r < tpc_pkg::NEXT_W'(tpc_pkg::NODE_POOL)) begin
            child_req.we         = 1'b1;
            child_req.waddr      = slot_r;
            child_req.wdata      = next_free_r[tpc_pkg::NODE_W-1:0];
            node_req.we          = 1'b1;
            node_req.waddr       = next_free_r[tpc_pkg::NODE_W-1:0];
            node_req.wdata.back  = slot_r;
            node_req.wdata.count = tpc_pkg::COUNT_BITS'(1);
            cur_nxt              = next_free_r[tpc_pkg::NODE_W-1:0];
            next_free_nxt        = next_free_r + tpc_pkg::NEXT_W'(1);
            val                  = tpc_pkg::COUNT_BITS'(1);
          end else begin
            full_nxt = 1'b1;
          end
        end else begin
          if (hit) begin
            cur_nxt = child_rdata;
            val     = node_rdata.count;
          end else begin
            broken_nxt = 1'b1;
          end
        end
        res_nxt.status       = full_nxt;
        res_nxt.prefix_count = (broken_nxt || full_nxt) ? '0 : tpc_pkg::count_to_field(val);
        state_nxt            = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (res_ready) begin
          cur_nxt    = '0;
          broken_nxt = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      next_free_r <= tpc_pkg::NEXT_W'(1);
      broken_r    <= 1'b0;
      full_r      <= 1'b0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      next_free_r <= next_free_nxt;
      broken_r    <= broken_nxt;
      full_r      <= full_nxt;
      clr_r       <= clr_nxt;
      clr_idx_r   <= clr_idx_nxt;
    end
    slot_r <= slot_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

endmodule

[rtl/tpc_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_out_stage
// Output register that holds one result until the master side takes it.
// ----------------------------------------------------------------------------
module tpc_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_valid,
  output logic                            res_ready,
  input  tpc_pkg::result_t                res,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic             valid_r, valid_nxt;
  tpc_pkg::result_t data_r, data_nxt;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = tpc_pkg::OUT_TDATA_W'({data_r.status, data_r.prefix_count});

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

endmodule

[rtl/trie_prefix_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_prefix_counter
// Letter-at-a-time trie with per-prefix counts in a fixed node pool.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (lsb up)                    tuser  tlast
//  in_      slave      letter[4:0], zero[7:5]            kind   last letter
//  out_     master     prefix_count[15:0], status[16],   -      -
//                      zero[23:17]
//
// A letter that looks up a child reads the child memory, then reads the node
// memory at the child found, then does the update. Letters of a word already
// broken or stopped, letters out of range, clears and the unused kind need no
// memory read. A last insert or query letter then waits in a final state to
// hand over the result. After reset a pass zeroes all NODE_POOL * ALPHABET =
// 106496 entries of the child memory, one entry a cycle, with in_tready low. A
// full output register stalls only a last letter, in its final state.
// ----------------------------------------------------------------------------
module trie_prefix_counter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tpc_pkg::IN_TDATA_W-1:0]  in_tdata,   // letter, zero fill
  input  logic [tpc_pkg::KIND_W-1:0]      in_tuser,   // kind
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpc_pkg::OUT_TDATA_W-1:0] out_tdata   // prefix_count, status, zero fill
);

  tpc_pkg::child_req_t child_req;
  tpc_pkg::node_t      child_rdata;
  tpc_pkg::node_req_t  node_req;
  tpc_pkg::node_word_t node_rdata;
  logic                res_valid;
  logic                res_ready;
  tpc_pkg::result_t    res;

  tpc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_letter   (in_tdata[tpc_pkg::LETTER_W-1:0]),
    .in_last     (in_tlast),
    .child_req   (child_req),
    .child_rdata (child_rdata),
    .node_req    (node_req),
    .node_rdata  (node_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  tpc_ram #(
    .WIDTH ($bits(tpc_pkg::node_t)),
    .DEPTH (tpc_pkg::SLOT_DEPTH)
  ) u_child_mem (
    .clk   (clk),
    .we    (child_req.we),
    .waddr (child_req.waddr),
    .wdata (child_req.wdata),
    .re    (child_req.re),
    .raddr (child_req.raddr),
    .rdata (child_rdata)
  );

  tpc_ram #(
    .WIDTH ($bits(tpc_pkg::node_word_t)),
    .DEPTH (tpc_pkg::NODE_POOL)
  ) u_node_mem (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .re    (node_req.re),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  tpc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/tpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks of the trie prefix counter, bound to the top level.
// ----------------------------------------------------------------------------
module tpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tpc_pkg::KIND_W-1:0]      in_tuser,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tpc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A stopped insert never reports a count.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("full status with nonzero count");

  // Reset starts the memory clearing pass, which holds off the input.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during clearing pass");

  // A last insert or query letter is never followed directly by another transfer.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast
      && (in_tuser == tpc_pkg::KIND_INSERT || in_tuser == tpc_pkg::KIND_QUERY)
      |=> !in_tready)
    else $error("input ready right after a last letter");

endmodule

bind trie_prefix_counter tpc_checker u_tpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
